@@ src/ptt_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the timer table
package ptt_pkg;

  // table size and field widths
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int PERIOD_W   = 32;
  localparam int TIME_W     = 48;
  localparam int STATUS_W   = 3;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                idx_clr;
    logic                idx_inc;
    logic                add_write;
    logic                remove;
    logic                div_start;
    logic                div_step;
    logic                best_clr;
    logic                best_upd;
    logic                res_we;
    logic [STATUS_W-1:0] res_status;
    logic                res_use_slot;
    logic                res_use_best;
    logic                out_load;
  } ptt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              period_zero;
    logic              table_full;
    logic              table_empty;
    logic              slot_bad;
    logic              cur_valid;
    logic              idx_last;
    logic              div_last;
  } ptt_sts_t;

endpackage

@@ src/ptt_ctrl.sv @@
// controller state machine: sequences add, remove and query requests
module ptt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ptt_pkg::ptt_sts_t sts,
  output ptt_pkg::ptt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_QCHK,
    S_DIV,
    S_ACC,
    S_QEND,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          ptt_pkg::MODE_ADD: begin
            if (sts.period_zero) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ptt_pkg::ST_ZERO;
              state_nxt      = S_FINISH;
            end else if (sts.table_full) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ptt_pkg::ST_FULL;
              state_nxt      = S_FINISH;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_FIND;
            end
          end
          ptt_pkg::MODE_REMOVE: begin
            cmd.res_we = 1'b1;
            if (sts.slot_bad) begin
              cmd.res_status = ptt_pkg::ST_UNUSED;
            end else begin
              cmd.remove     = 1'b1;
              cmd.res_status = ptt_pkg::ST_OK;
            end
            state_nxt = S_FINISH;
          end
          ptt_pkg::MODE_QUERY: begin
            if (sts.table_empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ptt_pkg::ST_EMPTY;
              state_nxt      = S_FINISH;
            end else begin
              cmd.idx_clr  = 1'b1;
              cmd.best_clr = 1'b1;
              state_nxt    = S_QCHK;
            end
          end
          default: begin
            // unused mode: plain ok result, no table change
            cmd.res_we     = 1'b1;
            cmd.res_status = ptt_pkg::ST_OK;
            state_nxt      = S_FINISH;
          end
        endcase
      end
      // walk to the lowest free slot; one exists since the table is not full
      S_FIND: begin
        if (!sts.cur_valid) begin
          cmd.add_write    = 1'b1;
          cmd.res_we       = 1'b1;
          cmd.res_status   = ptt_pkg::ST_OK;
          cmd.res_use_slot = 1'b1;
          state_nxt        = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // query: skip free slots, start the remainder unit on used ones
      S_QCHK: begin
        if (sts.cur_valid) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (sts.idx_last) begin
          state_nxt = S_QEND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.best_upd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_QEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_QCHK;
        end
      end
      S_QEND: begin
        cmd.res_we       = 1'b1;
        cmd.res_status   = ptt_pkg::ST_OK;
        cmd.res_use_best = 1'b1;
        state_nxt        = S_FINISH;
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/ptt_datapath.sv @@
// datapath: timer table, scan index, bit-serial remainder unit and minimum tracker
module ptt_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ptt_pkg::MODE_W-1:0]         in_mode,
  input  logic [ptt_pkg::SLOT_W-1:0]         in_slot,
  input  logic [ptt_pkg::PERIOD_W-1:0]       in_period_us,
  input  logic [ptt_pkg::TIME_W-1:0]         in_now_us,
  input  ptt_pkg::ptt_cmd_t                  cmd,
  output ptt_pkg::ptt_sts_t                  sts,
  output logic [ptt_pkg::STATUS_W-1:0]       out_status,
  output logic [ptt_pkg::SLOT_W-1:0]         out_slot_out,
  output logic [ptt_pkg::PERIOD_W-1:0]       out_time_to_next_us
);

  localparam int N   = ptt_pkg::TABLE_DEPTH;
  localparam int IW  = ptt_pkg::IDX_W;
  localparam int CW  = ptt_pkg::CNT_W;
  localparam int PW  = ptt_pkg::PERIOD_W;
  localparam int TW  = ptt_pkg::TIME_W;
  localparam int DCW = ptt_pkg::DIV_CNT_W;

  // request registers
  logic [ptt_pkg::MODE_W-1:0] mode_r;
  logic [ptt_pkg::SLOT_W-1:0] slot_r;
  logic [PW-1:0]              period_r;
  logic [TW-1:0]              now_r;

  // timer table
  logic [N-1:0]  entry_valid_r;
  logic [TW-1:0] entry_start_r  [N];
  logic [PW-1:0] entry_period_r [N];
  logic [CW-1:0] active_count_r;

  // scan and remainder unit
  logic [IW-1:0]  idx_r;
  logic [TW-1:0]  dvd_r;
  logic [PW-1:0]  rem_r;
  logic [PW-1:0]  div_per_r;
  logic [DCW-1:0] bit_cnt_r;
  logic [PW-1:0]  best_r;
  logic           found_r;

  // result staging and output registers
  logic [ptt_pkg::STATUS_W-1:0] res_status_r;
  logic [ptt_pkg::SLOT_W-1:0]   res_slot_r;
  logic [PW-1:0]                res_ttn_r;
  logic [ptt_pkg::STATUS_W-1:0] out_status_r;
  logic [ptt_pkg::SLOT_W-1:0]   out_slot_r;
  logic [PW-1:0]                out_ttn_r;

  logic [IW-1:0] slot_idx;
  logic          slot_range_bad;
  logic [PW:0]   trial;
  logic [PW:0]   trial_diff;
  logic [PW-1:0] remain;

  assign slot_idx       = IW'(slot_r);
  assign slot_range_bad = ({5'd0, slot_r} >= 9'(N));

  // status toward the controller
  assign sts.mode        = mode_r;
  assign sts.period_zero = (period_r == '0);
  assign sts.table_full  = (active_count_r == CW'(N));
  assign sts.table_empty = (active_count_r == '0);
  assign sts.slot_bad    = slot_range_bad || !entry_valid_r[slot_idx];
  assign sts.cur_valid   = entry_valid_r[idx_r];
  assign sts.idx_last    = (idx_r == IW'(N - 1));
  assign sts.div_last    = (bit_cnt_r == DCW'(TW - 1));

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem_r, dvd_r[TW-1]};
  assign trial_diff = trial - {1'b0, div_per_r};
  assign remain     = div_per_r - rem_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      slot_r   <= in_slot;
      period_r <= in_period_us;
      now_r    <= in_now_us;
    end
  end

  // valid bits and active count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r  <= '0;
      active_count_r <= '0;
    end else if (cmd.add_write) begin
      entry_valid_r[idx_r] <= 1'b1;
      active_count_r       <= active_count_r + CW'(1);
    end else if (cmd.remove) begin
      entry_valid_r[slot_idx] <= 1'b0;
      active_count_r          <= active_count_r - CW'(1);
    end
  end

  // start time and period of each entry
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      entry_start_r[idx_r]  <= now_r;
      entry_period_r[idx_r] <= period_r;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  // remainder of elapsed time by period, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r     <= now_r - entry_start_r[idx_r];
      div_per_r <= entry_period_r[idx_r];
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[TW-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + DCW'(1);
      if (!trial_diff[PW]) begin
        rem_r <= trial_diff[PW-1:0];
      end else begin
        rem_r <= trial[PW-1:0];
      end
    end
  end

  // smallest time to firing so far
  always_ff @(posedge clk) begin
    if (cmd.best_clr) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (cmd.best_upd) begin
      found_r <= 1'b1;
      if (!found_r || remain < best_r) begin
        best_r <= remain;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_use_slot ? ptt_pkg::SLOT_W'(idx_r) : '0;
      res_ttn_r    <= cmd.res_use_best ? best_r : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_ttn_r    <= res_ttn_r;
    end
  end

  assign out_status          = out_status_r;
  assign out_slot_out        = out_slot_r;
  assign out_time_to_next_us = out_ttn_r;

endmodule

@@ src/periodic_timer_table_core.sv @@
// top level of the periodic timer table: controller and datapath
//
// A table of 16 periodic timers. Each request adds a timer (period and
// start time, lowest free slot returned), removes one slot, or asks for the
// shortest time until any stored timer next fires. Requests are handled one at
// a time; a new request is taken while the previous result still waits in the
// output register. Remove and the flagged cases end without a scan, an add
// scans up from slot 0 to the first free slot, and a query visits every slot
// and runs the remainder unit on each occupied one. The query time is set by
// the bit-serial remainder unit, which divides the 48-bit elapsed time of each
// stored timer by its period.
module periodic_timer_table_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptt_pkg::MODE_W-1:0]         in_mode,
  input  logic [ptt_pkg::SLOT_W-1:0]         in_slot,
  input  logic [ptt_pkg::PERIOD_W-1:0]       in_period_us,
  input  logic [ptt_pkg::TIME_W-1:0]         in_now_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptt_pkg::STATUS_W-1:0]       out_status,
  output logic [ptt_pkg::SLOT_W-1:0]         out_slot_out,
  output logic [ptt_pkg::PERIOD_W-1:0]       out_time_to_next_us
);

  ptt_pkg::ptt_cmd_t cmd;
  ptt_pkg::ptt_sts_t sts;

  // request sequencing
  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and arithmetic
  ptt_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mode             (in_mode),
    .in_slot             (in_slot),
    .in_period_us        (in_period_us),
    .in_now_us           (in_now_us),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (out_status),
    .out_slot_out        (out_slot_out),
    .out_time_to_next_us (out_time_to_next_us)
  );

endmodule
